// ----- hw/rtl/vgar_pkg.sv -----
// Package for the video gate array register block: access kinds, register
// indexes, mode bit positions, draw modes and the page base helper.
// No dependencies.
`timescale 1ns / 1ps

package vgar_pkg;

  // Page and palette geometry
  localparam int PAGE_SIZE    = 16384;
  localparam int PALETTE_BASE = 16;
  localparam int ADDR_W       = 17;

  // Bus access kinds
  typedef enum logic [1:0] {
    KIND_GATE   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_PAGE   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Gate-array register indexes below the palette window
  localparam logic [4:0] REG_MODE1  = 5'd0;
  localparam logic [4:0] REG_MASK   = 5'd1;
  localparam logic [4:0] REG_BORDER = 5'd2;
  localparam logic [4:0] REG_MODE2  = 5'd3;
  localparam logic [4:0] REG_RESET  = 5'd4;

  // Mode bit positions
  localparam int MB_HIBW  = 0;
  localparam int MB_GFX   = 1;
  localparam int MB_MONO  = 2;
  localparam int MB_VIDEO = 3;
  localparam int MB_G16   = 4;
  localparam int MB_BLINK = 5;
  localparam int MB_G2    = 6;

  // Status byte bit positions
  localparam int ST_DISP  = 0;
  localparam int ST_PEN   = 2;
  localparam int ST_VSYNC = 3;
  localparam int ST_DOT   = 4;

  typedef enum logic [2:0] {
    DRAW_TEXT   = 3'd0,
    DRAW_640X2  = 3'd1,
    DRAW_320X16 = 3'd2,
    DRAW_160X16 = 3'd3,
    DRAW_640X4  = 3'd4,
    DRAW_320X4  = 3'd5
  } draw_mode_e;

  // Page number times page size, wrapped to the address width
  function automatic logic [ADDR_W-1:0] page_base(input logic [2:0] page);
    logic [31:0] prod;
    prod = {29'd0, page} * 32'(PAGE_SIZE);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/video_gate_array_regs.sv -----
// Register block of the video gate array: bus access decode, register
// state and result packing. Depends on vgar_pkg.
`timescale 1ns / 1ps

// Takes one bus access per transfer on the input channel (gate-array write,
// status read or page write) and returns one result transfer for each. The
// block accepts one access per cycle unless the input stalls; an access is
// held in the input register and its result is registered in the result
// register when that register is empty or being drained, so a new access
// can enter before the last one has left. The result
// shows the state after the access: status (zero unless a status read),
// page base addresses, address mode, mode control bits, border and mask,
// draw mode with its pixel divider, and the palette entry at palette_pick.
// A stalled result holds; the input stalls only when both stages are full.
module video_gate_array_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_i,
  input  logic        display_active_i,
  input  logic        vsync_active_i,
  input  logic [3:0]  last_dot_i,
  input  logic [3:0]  palette_pick_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  status_byte_o,
  output logic [16:0] crt_base_address_o,
  output logic [16:0] cpu_base_address_o,
  output logic [1:0]  address_mode_o,
  output logic        video_enabled_o,
  output logic        monochrome_o,
  output logic        blink_enable_o,
  output logic [3:0]  border_color_o,
  output logic [3:0]  palette_mask_out_o,
  output logic [2:0]  draw_mode_o,
  output logic [2:0]  x_divider_o,
  output logic [3:0]  palette_entry_o
);

  // ---------------------------------------------------------------------
  // Handshake: input register feeding the result register
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_ready;
  logic fire;
  logic in_load;

  // Result register can take a new value when empty or being drained
  assign out_ready  = !out_valid_q || !out_stall_i;
  // Advance the item in the input register into the result register
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  // Input register payload
  vgar_pkg::kind_e s1_kind_q;
  logic [7:0]      s1_data_q;
  logic            s1_disp_q;
  logic            s1_vsync_q;
  logic [3:0]      s1_dot_q;
  logic [3:0]      s1_pick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_kind_q  <= vgar_pkg::kind_e'(kind_i);
      s1_data_q  <= data_i;
      s1_disp_q  <= display_active_i;
      s1_vsync_q <= vsync_active_i;
      s1_dot_q   <= last_dot_i;
      s1_pick_q  <= palette_pick_i;
    end
  end

  // ---------------------------------------------------------------------
  // Register state
  // ---------------------------------------------------------------------
  logic       phase_q,  phase_d;   // 0 address phase, 1 data phase
  logic [4:0] index_q,  index_d;
  logic [6:0] mode_q,   mode_d;
  logic [3:0] mask_q,   mask_d;
  logic [3:0] border_q, border_d;
  logic [7:0] page_q,   page_d;    // [2:0] CRT, [5:3] CPU, [7:6] address mode
  logic [3:0] palette_q [16];
  logic       pal_we;
  logic [3:0] pal_waddr;
  logic [4:0] status_d;

  // Palette window starts at PALETTE_BASE and covers sixteen indexes
  assign pal_waddr = 4'(index_q - 5'(vgar_pkg::PALETTE_BASE));

  always_comb begin
    logic [2:0] crt;
    phase_d  = phase_q;
    index_d  = index_q;
    mode_d   = mode_q;
    mask_d   = mask_q;
    border_d = border_q;
    page_d   = page_q;
    pal_we   = 1'b0;
    status_d = '0;
    crt      = s1_data_q[2:0];

    case (s1_kind_q)
      vgar_pkg::KIND_GATE: begin
        phase_d = !phase_q;
        if (!phase_q) begin
          // Address phase: keep the register index
          index_d = s1_data_q[4:0];
        end else if (index_q >= 5'(vgar_pkg::PALETTE_BASE)) begin
          pal_we = 1'b1;
        end else begin
          unique case (index_q)
            vgar_pkg::REG_MODE1: begin
              mode_d[4:0] = s1_data_q[4:0];
            end
            vgar_pkg::REG_MASK: begin
              mask_d = s1_data_q[3:0];
            end
            vgar_pkg::REG_BORDER: begin
              border_d = s1_data_q[3:0];
            end
            vgar_pkg::REG_MODE2: begin
              mode_d[vgar_pkg::MB_BLINK] = s1_data_q[1];
              mode_d[vgar_pkg::MB_G2]    = s1_data_q[3];
            end
            // Reset register and unknown indexes: write nothing
            default: begin
            end
          endcase
        end
      end
      vgar_pkg::KIND_STATUS: begin
        phase_d = 1'b0;
        status_d[vgar_pkg::ST_DISP]  = s1_disp_q;
        status_d[vgar_pkg::ST_PEN]   = 1'b1;
        status_d[vgar_pkg::ST_VSYNC] = s1_vsync_q;
        status_d[vgar_pkg::ST_DOT]   = s1_dot_q[index_q[1:0]];
      end
      vgar_pkg::KIND_PAGE: begin
        // High-bandwidth graphics forces an even CRT page
        if (mode_q[vgar_pkg::MB_HIBW] && mode_q[vgar_pkg::MB_GFX]) begin
          crt[0] = 1'b0;
        end
        page_d = {s1_data_q[7:3], crt};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      index_q  <= '0;
      mode_q   <= '0;
      mask_q   <= '0;
      border_q <= '0;
      page_q   <= '0;
      for (int i = 0; i < 16; i++) begin
        palette_q[i] <= '0;
      end
    end else if (fire) begin
      phase_q  <= phase_d;
      index_q  <= index_d;
      mode_q   <= mode_d;
      mask_q   <= mask_d;
      border_q <= border_d;
      page_q   <= page_d;
      if (pal_we) begin
        palette_q[pal_waddr] <= s1_data_q[3:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result packing from the updated state
  // ---------------------------------------------------------------------
  vgar_pkg::draw_mode_e draw_d;
  logic [2:0]           div_d;
  logic [3:0]           pal_rd;

  always_comb begin
    if (!mode_d[vgar_pkg::MB_GFX]) begin
      draw_d = vgar_pkg::DRAW_TEXT;
      div_d  = 3'd2;
    end else if (mode_d[vgar_pkg::MB_G2]) begin
      draw_d = vgar_pkg::DRAW_640X2;
      div_d  = 3'd1;
    end else if (mode_d[vgar_pkg::MB_G16]) begin
      draw_d = mode_d[vgar_pkg::MB_HIBW] ? vgar_pkg::DRAW_320X16 : vgar_pkg::DRAW_160X16;
      div_d  = 3'd4;
    end else if (mode_d[vgar_pkg::MB_HIBW]) begin
      draw_d = vgar_pkg::DRAW_640X4;
      div_d  = 3'd2;
    end else begin
      draw_d = vgar_pkg::DRAW_320X4;
      div_d  = 3'd2;
    end
  end

  // Bypass the palette write so the result sees the updated entry
  assign pal_rd = (pal_we && pal_waddr == s1_pick_q) ? s1_data_q[3:0]
                                                    : palette_q[s1_pick_q];

  logic [4:0]  status_q;
  logic [16:0] crt_base_q;
  logic [16:0] cpu_base_q;
  logic [1:0]  amode_q;
  logic        video_q;
  logic        mono_q;
  logic        blink_q;
  logic [3:0]  border_out_q;
  logic [3:0]  mask_out_q;
  logic [2:0]  draw_q;
  logic [2:0]  div_q;
  logic [3:0]  pal_out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q     <= status_d;
      crt_base_q   <= vgar_pkg::page_base(page_d[2:0]);
      cpu_base_q   <= vgar_pkg::page_base(page_d[5:3]);
      amode_q      <= page_d[7:6];
      video_q      <= mode_d[vgar_pkg::MB_VIDEO];
      mono_q       <= mode_d[vgar_pkg::MB_MONO];
      blink_q      <= mode_d[vgar_pkg::MB_BLINK];
      border_out_q <= border_d;
      mask_out_q   <= mask_d;
      draw_q       <= draw_d;
      div_q        <= div_d;
      pal_out_q    <= pal_rd;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_byte_o      = status_q;
  assign crt_base_address_o = crt_base_q;
  assign cpu_base_address_o = cpu_base_q;
  assign address_mode_o     = amode_q;
  assign video_enabled_o    = video_q;
  assign monochrome_o       = mono_q;
  assign blink_enable_o     = blink_q;
  assign border_color_o     = border_out_q;
  assign palette_mask_out_o = mask_out_q;
  assign draw_mode_o        = draw_q;
  assign x_divider_o        = div_q;
  assign palette_entry_o    = pal_out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A status read leaves the flip-flop in address phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_kind_q == vgar_pkg::KIND_STATUS |=> !phase_q)
    else $error("status read did not clear the phase flip-flop");

  // Only a status read reports a non-zero status byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_kind_q != vgar_pkg::KIND_STATUS |=> status_q == 5'd0)
    else $error("status byte set by an access that is not a status read");

  // Page write in high-bandwidth graphics stores an even CRT page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_kind_q == vgar_pkg::KIND_PAGE
      && mode_q[vgar_pkg::MB_HIBW] && mode_q[vgar_pkg::MB_GFX] |=> !page_q[0])
    else $error("odd CRT page stored in high-bandwidth graphics");

  // Input stalls only when both stages hold an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // Divider is always one of the legal values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> div_q == 3'd1 || div_q == 3'd2 || div_q == 3'd4)
    else $error("illegal pixel divider");

endmodule
